@@ hdl/bbpb_pkg.sv @@
`default_nettype none
package bbpb_pkg;

  localparam int MAX_SOURCE_WIDTH_DEF  = 64;
  localparam int MAX_SOURCE_HEIGHT_DEF = 64;
  localparam int MAX_BLOOM_WIDTH_DEF   = 32;
  localparam int MAX_BLOOM_HEIGHT_DEF  = 32;
  localparam int MAX_TAPS_DEF          = 9;

  // Request codes.
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_RUN   = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SRC_W   = 3'd0;
  localparam logic [2:0] REG_SRC_H   = 3'd1;
  localparam logic [2:0] REG_BLM_W   = 3'd2;
  localparam logic [2:0] REG_BLM_H   = 3'd3;
  localparam logic [2:0] REG_THRESH  = 3'd4;
  localparam logic [2:0] REG_HALF    = 3'd5;
  localparam logic [2:0] REG_WEIGHTS = 3'd6;

  // Luminance coefficients, Q0.16, summing to one.
  localparam logic [15:0] LUM_R = 16'd13933;
  localparam logic [15:0] LUM_G = 16'd46871;
  localparam logic [15:0] LUM_B = 16'd4732;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] pixel_index;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
  } bbpb_req_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        status;
  } bbpb_rsp_t;

endpackage
`default_nettype wire

@@ hdl/bbpb_ram.sv @@
`default_nettype none
module bbpb_ram #(
  parameter int W     = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/bbpb_div.sv @@
`default_nettype none
module bbpb_div #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [DW-1:0] quo
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     shifted;
  logic [DW:0]     trial;

  // One quotient bit per cycle, restoring.
  assign shifted = {rem, quo[DW-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= num;
        dsr <= den;
        cnt <= CNTW'(DW);
      end else if (cnt != '0) begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= shifted[DW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/bloom_bright_pass_blur_core.sv @@
`default_nettype none
// Channel  Signals                          Moves
// -------  -------------------------------  -------------------------------------
// req      req_valid, req_ready, req        one command word: write, run or read
// rsp      rsp_valid, rsp_ready, rsp        one response word per command
// cfg      cfg_valid, cfg_ready, cfg_index,  one register write, always ready
//          cfg_data
//
// A pixel write's response word is presented on the next edge.
// A pixel read passes the registered bloom-memory read, then the response register.
// A run walks the whole image. Per bloom pixel it costs seven passes of the shared
// one-bit-per-cycle divider, ten when the pixel clears the threshold, and one read
// per source pixel of its block; two blur passes over the bloom image then follow.
// Reset is synchronous and clears control state and the configuration registers;
// memories are not cleared. A command is taken only in idle, and only while the
// response register is empty or is being emptied in the same cycle, so a waiting
// response word holds off the next command.
module bloom_bright_pass_blur_core
  import bbpb_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_SOURCE_HEIGHT = MAX_SOURCE_HEIGHT_DEF,
  parameter int MAX_BLOOM_WIDTH   = MAX_BLOOM_WIDTH_DEF,
  parameter int MAX_BLOOM_HEIGHT  = MAX_BLOOM_HEIGHT_DEF,
  parameter int MAX_TAPS          = MAX_TAPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire bbpb_req_t   req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output bbpb_rsp_t        rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [59:0] cfg_data
);

  localparam int SRC_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int SRC_AW    = $clog2(SRC_DEPTH);
  localparam int BLM_DEPTH = MAX_BLOOM_WIDTH * MAX_BLOOM_HEIGHT;
  localparam int BLM_AW    = (BLM_DEPTH > 1) ? $clog2(BLM_DEPTH) : 1;
  localparam int MAXS      = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                             MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
  localparam int MAXD      = (MAXS > MAX_BLOOM_WIDTH) ?
                             ((MAXS > MAX_BLOOM_HEIGHT) ? MAXS : MAX_BLOOM_HEIGHT) :
                             ((MAX_BLOOM_WIDTH > MAX_BLOOM_HEIGHT) ?
                              MAX_BLOOM_WIDTH : MAX_BLOOM_HEIGHT);
  localparam int CW        = $clog2(MAXD + 1);
  localparam int PW        = CW + 2;
  localparam int NW        = $clog2(SRC_DEPTH + 1);
  localparam int SUMW      = 16 + NW;
  localparam int DIV_W     = (SUMW > 32) ? SUMW : 32;
  localparam int HMAX_RAW  = (MAX_TAPS - 1) / 2;
  localparam int HMAX      = (HMAX_RAW > 4) ? 4 : HMAX_RAW;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RD   = 14'b00000000000010,
    S_BND  = 14'b00000000000100,
    S_ACC  = 14'b00000000001000,
    S_ACCW = 14'b00000000010000,
    S_AVG  = 14'b00000000100000,
    S_LUM0 = 14'b00000001000000,
    S_LUM1 = 14'b00000010000000,
    S_BP   = 14'b00000100000000,
    S_BWR  = 14'b00001000000000,
    S_TAP  = 14'b00010000000000,
    S_TDRN = 14'b00100000000000,
    S_TWR  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0]  source_width;
  logic [6:0]  source_height;
  logic [5:0]  bloom_width;
  logic [5:0]  bloom_height;
  logic [15:0] bright_threshold;
  logic [2:0]  blur_half_taps;
  logic [59:0] blur_weights;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width     <= 7'd64;
      source_height    <= 7'd64;
      bloom_width      <= 6'd32;
      bloom_height     <= 6'd32;
      bright_threshold <= 16'd52429;
      blur_half_taps   <= 3'd2;
      blur_weights     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_W:   source_width     <= cfg_data[6:0];
        REG_SRC_H:   source_height    <= cfg_data[6:0];
        REG_BLM_W:   bloom_width      <= cfg_data[5:0];
        REG_BLM_H:   bloom_height     <= cfg_data[5:0];
        REG_THRESH:  bright_threshold <= cfg_data[15:0];
        REG_HALF:    blur_half_taps   <= cfg_data[2:0];
        REG_WEIGHTS: blur_weights     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes saturated to one through their maximum.
  logic [CW-1:0] sw, sh, bw, bh;
  logic [2:0]    half;

  always_comb begin
    sw = (source_width == '0) ? CW'(1) :
         ((32'(source_width) > MAX_SOURCE_WIDTH) ? CW'(MAX_SOURCE_WIDTH) :
          CW'(source_width));
    sh = (source_height == '0) ? CW'(1) :
         ((32'(source_height) > MAX_SOURCE_HEIGHT) ? CW'(MAX_SOURCE_HEIGHT) :
          CW'(source_height));
    bw = (bloom_width == '0) ? CW'(1) :
         ((32'(bloom_width) > MAX_BLOOM_WIDTH) ? CW'(MAX_BLOOM_WIDTH) :
          CW'(bloom_width));
    bh = (bloom_height == '0) ? CW'(1) :
         ((32'(bloom_height) > MAX_BLOOM_HEIGHT) ? CW'(MAX_BLOOM_HEIGHT) :
          CW'(bloom_height));
    half = (32'(blur_half_taps) > HMAX) ? 3'(HMAX) : blur_half_taps;
  end

  logic [2*CW-1:0] src_lim, blm_lim;
  logic [31:0]     pidx;
  logic            req_acc;
  logic            src_in_range, blm_in_range;

  assign src_lim      = sw * sh;
  assign blm_lim      = bw * bh;
  assign pidx         = 32'(req.pixel_index);
  assign src_in_range = pidx < 32'(src_lim);
  assign blm_in_range = pidx < 32'(blm_lim);
  assign req_ready    = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_acc      = req_valid && req_ready;

  // Sequencer registers.
  logic [CW-1:0]   j, i, y, x, y0, y1, x0, x1;
  logic [1:0]      bsel;
  logic [1:0]      ch;
  logic            pass;
  logic [3:0]      t;
  logic            dv_wait;
  logic            div_go;
  logic [DIV_W-1:0] div_num, div_den;
  logic            div_done;
  logic [DIV_W-1:0] div_quo;
  logic [SUMW-1:0] s [3];
  logic [NW-1:0]   n;
  logic            acc_v;
  logic [15:0]     a [3];
  logic [15:0]     o [3];
  logic [31:0]     p [3];
  logic [15:0]     lum;
  logic            rv1, pv;
  logic [11:0]     w1;
  logic [27:0]     prod [3];
  logic [31:0]     acc [3];

  bbpb_div #(.DW(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Memories.
  logic [47:0]       src_rdata, blm_rdata, row_rdata;
  logic              src_we, blm_we, row_we;
  logic [SRC_AW-1:0] src_raddr;
  logic [BLM_AW-1:0] blm_raddr, blm_waddr;
  logic [47:0]       blm_wdata, sat_word;
  logic [2*CW-1:0]   src_lin, wr_lin, blur_lin;

  assign src_lin  = y * sw + (2*CW)'(x);
  assign src_raddr = src_lin[SRC_AW-1:0];
  assign src_we   = req_acc && (req.func == FN_WRITE) && src_in_range;

  bbpb_ram #(.W(48), .DEPTH(SRC_DEPTH), .AW(SRC_AW)) u_src (
    .clk   (clk),
    .we    (src_we),
    .waddr (pidx[SRC_AW-1:0]),
    .wdata ({req.in_blue, req.in_green, req.in_red}),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  // Blur tap: signed offset, its weight and the clamped position.
  logic signed [4:0]    dd;
  logic [2:0]           ad;
  logic [11:0]          wsel;
  logic signed [PW-1:0] praw;
  logic [CW-1:0]        pos, base, plim;

  always_comb begin
    dd   = $signed({1'b0, t}) - $signed({2'b00, half});
    ad   = (dd < 0) ? 3'(-dd) : 3'(dd);
    wsel = blur_weights[12*ad +: 12];
    base = pass ? j : i;
    plim = pass ? bh : bw;
    praw = $signed({2'b00, base}) + PW'(dd);
    if (praw < 0) begin
      pos = '0;
    end else if (praw > $signed({2'b00, plim}) - 1) begin
      pos = plim - 1'b1;
    end else begin
      pos = CW'(praw);
    end
  end

  assign blur_lin = (pass ? pos : j) * bw + (2*CW)'(pass ? i : pos);
  assign wr_lin   = j * bw + (2*CW)'(i);
  assign blm_waddr = wr_lin[BLM_AW-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_word[16*c +: 16] = (|acc[c][31:28]) ? 16'hFFFF : acc[c][27:12];
    end
  end

  assign blm_we    = (state == S_BWR) || ((state == S_TWR) && pass);
  assign blm_wdata = (state == S_BWR) ? {o[2], o[1], o[0]} : sat_word;
  assign blm_raddr = (state == S_TAP) ? blur_lin[BLM_AW-1:0] : pidx[BLM_AW-1:0];
  assign row_we    = (state == S_TWR) && !pass;

  bbpb_ram #(.W(48), .DEPTH(BLM_DEPTH), .AW(BLM_AW)) u_bloom (
    .clk   (clk),
    .we    (blm_we),
    .waddr (blm_waddr),
    .wdata (blm_wdata),
    .raddr (blm_raddr),
    .rdata (blm_rdata)
  );

  bbpb_ram #(.W(48), .DEPTH(BLM_DEPTH), .AW(BLM_AW)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (blm_waddr),
    .wdata (sat_word),
    .raddr (blur_lin[BLM_AW-1:0]),
    .rdata (row_rdata)
  );

  logic [47:0] tap_data;
  assign tap_data = pass ? row_rdata : blm_rdata;

  logic            last_px;
  logic [CW-1:0]   bsize, bcoord;
  logic [2*CW-1:0] bprod;

  assign last_px = (i == bw - 1'b1) && (j == bh - 1'b1);
  assign bcoord  = bsel[1] ? i : j;
  assign bsize   = bsel[1] ? sw : sh;
  assign bprod   = (bcoord + CW'(bsel[0])) * bsize;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      div_go    <= 1'b0;
      dv_wait   <= 1'b0;
      acc_v     <= 1'b0;
      rv1       <= 1'b0;
      pv        <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // Block accumulation, one source pixel in the cycle after its read.
      acc_v <= (state == S_ACC);
      if (acc_v) begin
        for (int c = 0; c < 3; c++) begin
          s[c] <= s[c] + SUMW'(src_rdata[16*c +: 16]);
        end
        n <= n + 1'b1;
      end

      // Blur multiply-accumulate pipeline.
      rv1 <= (state == S_TAP);
      w1  <= wsel;
      pv  <= rv1;
      if (rv1) begin
        for (int c = 0; c < 3; c++) begin
          prod[c] <= tap_data[16*c +: 16] * w1;
        end
      end
      if (pv) begin
        for (int c = 0; c < 3; c++) begin
          acc[c] <= acc[c] + 32'(prod[c]);
        end
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            rsp <= '0;
            case (req.func)
              FN_WRITE: begin
                rsp.status <= !src_in_range;
                rsp_valid  <= 1'b1;
              end
              FN_RUN: begin
                j       <= '0;
                i       <= '0;
                bsel    <= '0;
                dv_wait <= 1'b0;
                state   <= S_BND;
              end
              FN_READ: begin
                if (blm_in_range) begin
                  state <= S_RD;
                end else begin
                  rsp.status <= 1'b1;
                  rsp_valid  <= 1'b1;
                end
              end
              default: begin
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end

        S_RD: begin
          rsp.out_red   <= blm_rdata[15:0];
          rsp.out_green <= blm_rdata[31:16];
          rsp.out_blue  <= blm_rdata[47:32];
          rsp.status    <= 1'b0;
          rsp_valid     <= 1'b1;
          state         <= S_IDLE;
        end

        // Block bounds: y0, y1, x0, x1 through the divider.
        S_BND: begin
          if (!dv_wait) begin
            div_num <= DIV_W'(bprod);
            div_den <= DIV_W'(bsel[1] ? bw : bh);
            div_go  <= 1'b1;
            dv_wait <= 1'b1;
          end else if (div_done) begin
            dv_wait <= 1'b0;
            bsel    <= bsel + 1'b1;
            case (bsel)
              2'd0: y0 <= CW'(div_quo);
              2'd1: y1 <= (div_quo > DIV_W'(sh) - 1) ? sh - 1'b1 : CW'(div_quo);
              2'd2: x0 <= CW'(div_quo);
              default: begin
                x1 <= (div_quo > DIV_W'(sw) - 1) ? sw - 1'b1 : CW'(div_quo);
                y  <= y0;
                x  <= x0;
                for (int c = 0; c < 3; c++) begin
                  s[c] <= '0;
                end
                n     <= '0;
                state <= S_ACC;
              end
            endcase
          end
        end

        S_ACC: begin
          if (x == x1) begin
            x <= x0;
            if (y == y1) begin
              state <= S_ACCW;
            end else begin
              y <= y + 1'b1;
            end
          end else begin
            x <= x + 1'b1;
          end
        end

        S_ACCW: begin
          ch    <= '0;
          state <= S_AVG;
        end

        S_AVG: begin
          if (!dv_wait) begin
            div_num <= DIV_W'(s[ch]);
            div_den <= DIV_W'(n);
            div_go  <= 1'b1;
            dv_wait <= 1'b1;
          end else if (div_done) begin
            dv_wait <= 1'b0;
            a[ch]   <= div_quo[15:0];
            ch      <= ch + 1'b1;
            if (ch == 2'd2) begin
              state <= S_LUM0;
            end
          end
        end

        S_LUM0: begin
          p[0]  <= a[0] * LUM_R;
          p[1]  <= a[1] * LUM_G;
          p[2]  <= a[2] * LUM_B;
          state <= S_LUM1;
        end

        S_LUM1: begin
          lum   <= 16'((34'(p[0]) + 34'(p[1]) + 34'(p[2])) >> 16);
          ch    <= '0;
          state <= S_BP;
        end

        // Bright pass: scale by (lum - threshold) / lum, or zero.
        S_BP: begin
          if (lum <= bright_threshold) begin
            for (int c = 0; c < 3; c++) begin
              o[c] <= '0;
            end
            state <= S_BWR;
          end else if (!dv_wait) begin
            div_num <= DIV_W'(32'(a[ch]) * 32'(lum - bright_threshold));
            div_den <= DIV_W'(lum);
            div_go  <= 1'b1;
            dv_wait <= 1'b1;
          end else if (div_done) begin
            dv_wait <= 1'b0;
            o[ch]   <= div_quo[15:0];
            ch      <= ch + 1'b1;
            if (ch == 2'd2) begin
              state <= S_BWR;
            end
          end
        end

        S_BWR: begin
          bsel <= '0;
          if (last_px) begin
            i     <= '0;
            j     <= '0;
            pass  <= 1'b0;
            t     <= '0;
            for (int c = 0; c < 3; c++) begin
              acc[c] <= '0;
            end
            state <= S_TAP;
          end else begin
            if (i == bw - 1'b1) begin
              i <= '0;
              j <= j + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
            state <= S_BND;
          end
        end

        S_TAP: begin
          t <= t + 1'b1;
          if (t == {half, 1'b0}) begin
            state <= S_TDRN;
          end
        end

        S_TDRN: begin
          if (!rv1 && !pv) begin
            state <= S_TWR;
          end
        end

        S_TWR: begin
          t <= '0;
          for (int c = 0; c < 3; c++) begin
            acc[c] <= '0;
          end
          if (last_px) begin
            i <= '0;
            j <= '0;
            if (pass) begin
              state <= S_DONE;
            end else begin
              pass  <= 1'b1;
              state <= S_TAP;
            end
          end else begin
            if (i == bw - 1'b1) begin
              i <= '0;
              j <= j + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
            state <= S_TAP;
          end
        end

        S_DONE: begin
          rsp       <= '0;
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/bbpb_checker.sv @@
`default_nettype none
module bbpb_checker
  import bbpb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire bbpb_req_t   req,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire bbpb_rsp_t   rsp,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [59:0] cfg_data
);

  // A response word waits until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word dropped or changed while stalled");

  // An out-of-range status never carries color.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |->
      rsp.out_red == 16'd0 && rsp.out_green == 16'd0 && rsp.out_blue == 16'd0)
    else $error("error response carries pixel data");

  // Writes and unused codes answer on the next edge.
  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.func != FN_RUN && req.func != FN_READ
      |=> rsp_valid)
    else $error("write gave no response on the next cycle");

  // A read either answers at once or holds off the next command while memory is read.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.func == FN_READ |=> !req_ready || rsp_valid)
    else $error("command accepted during a read");

  // Nothing is presented right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind bloom_bright_pass_blur_core bbpb_checker u_bbpb_checker (.*);
`default_nettype wire
